FILE: sv/ordered_list_insert_delete_core_assert.svh
// Assertion macros shared by the ordered list core.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef ORDERED_LIST_INSERT_DELETE_CORE_ASSERT_SVH
`define ORDERED_LIST_INSERT_DELETE_CORE_ASSERT_SVH
`ifndef SYNTH
// Checks that a condition holds at every clock edge.
`define OLIDC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Checks that a trigger is followed in the next cycle by a required condition.
`define OLIDC_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);
`else
`define OLIDC_ASSERT_ALWAYS(lbl, cond, msg)
`define OLIDC_ASSERT_NEXT(lbl, trig, cons, msg)
`endif
`endif

FILE: sv/ordlst_pkg.sv
package ordlst_pkg;

    // Fixed widths of the request and response fields.
    localparam int OPCODE_W  = 2;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int ENTRY_CNT_W = 5;

    // Default sizes of the list.
    localparam int DEF_CAPACITY    = 16;
    localparam int DEF_VALUE_WIDTH = 32;

    // Operation codes.
    localparam logic [OPCODE_W-1:0] OP_INS_HEAD = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_INS_TAIL = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_DELETE   = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // Commands broadcast from the control logic to every cell of the row.
    typedef struct packed {
        logic shift_in;  // everything moves one place toward the tail
        logic append;    // the first empty cell takes the new value
        logic remove;    // cells at or past the first match take their right neighbor
    } ordlst_ctrl_t;

endpackage

FILE: sv/ordlst_in_if.sv
interface ordlst_in_if;
    import ordlst_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [VALUE_W-1:0]  value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

FILE: sv/ordlst_out_if.sv
interface ordlst_out_if;
    import ordlst_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [ENTRY_CNT_W-1:0] entry_count;
    logic [VALUE_W-1:0]     head_value;
    logic [VALUE_W-1:0]     tail_value;

    modport source (output valid, output status, output entry_count,
                    output head_value, output tail_value, input ready);
    modport sink   (input valid, input status, input entry_count,
                    input head_value, input tail_value, output ready);
endinterface

FILE: sv/ordlst_cell.sv
module ordlst_cell #(
    parameter int VALUE_WIDTH = ordlst_pkg::DEF_VALUE_WIDTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ordlst_pkg::ordlst_ctrl_t  ctrl,
    input  logic [VALUE_WIDTH-1:0]    ins_value,
    input  logic [VALUE_WIDTH-1:0]    left_value,
    input  logic                      left_valid,
    input  logic [VALUE_WIDTH-1:0]    right_value,
    input  logic                      right_valid,
    input  logic                      found_in,
    output logic                      found_out,
    output logic [VALUE_WIDTH-1:0]    value,
    output logic                      valid,
    output logic [VALUE_WIDTH-1:0]    tail_term
);
    import ordlst_pkg::*;

    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic                   valid_reg, valid_next;
    logic                   match;

    // A cell matches only while it holds an entry; the found flag ripples
    // toward the tail so only the first match and the cells after it move.
    assign match     = valid_reg && (value_reg == ins_value);
    assign found_out = found_in || match;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        priority if (ctrl.shift_in)
        begin
            value_next = left_value;
            valid_next = left_valid;
        end
        else if (ctrl.append && !valid_reg && left_valid)
        begin
            value_next = ins_value;
            valid_next = 1'b1;
        end
        else if (ctrl.remove && found_out)
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
        else
        begin
            value_next = value_reg;
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value     = value_reg;
    assign valid     = valid_reg;
    assign tail_term = (valid_reg && !right_valid) ? value_reg : '0;

endmodule

FILE: sv/ordered_list_insert_delete_core.sv
// A request is accepted into the pending stage, which carries its status while the cell
// row updates; the response stage then registers status, count, head and tail values.
// A new request is not taken while the previous one is pending; the cell row updates
// at acceptance and the response stage samples it when the pending stage hands it on.
// A response held on a stalled output only delays the next request until it is taken.
// Reset (rst_n, asynchronous, active low) empties the list and clears handshake state;
// stored values are not cleared and are never shown while their cell is empty.
`include "ordered_list_insert_delete_core_assert.svh"

module ordered_list_insert_delete_core #(
    parameter int CAPACITY    = ordlst_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = ordlst_pkg::DEF_VALUE_WIDTH
) (
    input logic         clk,
    input logic         rst_n,
    ordlst_in_if.sink   req,
    ordlst_out_if.source rsp
);
    import ordlst_pkg::*;

    // The count must be able to hold CAPACITY itself.
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // The list lives in a row of cells, head at cell zero. Each cell holds one
    // value and a valid bit; the valid bits are always packed from the head.
    logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
    logic [VALUE_WIDTH-1:0] cell_tail  [CAPACITY];
    logic [CAPACITY-1:0]    cell_valid;
    logic [CAPACITY-1:0]    found_chain;

    logic [VALUE_WIDTH-1:0] ins_value;
    logic                   accept;
    logic                   full;
    logic                   found_any;
    ordlst_ctrl_t           ctrl;
    logic [STATUS_W-1:0]    status_now;
    logic [VALUE_WIDTH-1:0] tail_any;
    logic                   load_rsp;

    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   pend_reg, pend_next;
    logic [STATUS_W-1:0]    pend_status_reg, pend_status_next;

    logic                   rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]    rsp_status_reg, rsp_status_next;
    logic [ENTRY_CNT_W-1:0] rsp_count_reg, rsp_count_next;
    logic [VALUE_W-1:0]     rsp_head_reg, rsp_head_next;
    logic [VALUE_W-1:0]     rsp_tail_reg, rsp_tail_next;

    // Only the low VALUE_WIDTH bits of a request value are stored and compared.
    assign ins_value = VALUE_WIDTH'(req.value);

    // A request is taken whenever the previous one has left the cell row for
    // the response stage; a waiting response holds the pending stage, and with
    // it the input.
    assign req.ready = !pend_reg;
    assign accept    = req.valid && !pend_reg;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign found_any = found_chain[CAPACITY-1];

    // Commands to the row. Rejected inserts and failed deletes leave it untouched.
    always_comb
    begin
        ctrl.shift_in = accept && (req.opcode == OP_INS_HEAD) && !full;
        ctrl.append   = accept && (req.opcode == OP_INS_TAIL) && !full;
        ctrl.remove   = accept && (req.opcode == OP_DELETE) && found_any;
    end

    always_comb
    begin
        unique case (req.opcode)
            OP_INS_HEAD, OP_INS_TAIL: status_now = full ? ST_FULL : ST_DONE;
            OP_DELETE:                status_now = found_any ? ST_DONE : ST_NOT_FOUND;
            default:                  status_now = ST_DONE;
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [VALUE_WIDTH-1:0] left_value;
            logic                   left_valid;
            logic [VALUE_WIDTH-1:0] right_value;
            logic                   right_valid;
            logic                   found_in;

            // The head cell sees the new value on its left as an occupied
            // neighbor; the last cell sees an empty neighbor on its right.
            if (gi == 0)
            begin : g_head
                assign left_value = ins_value;
                assign left_valid = 1'b1;
                assign found_in   = 1'b0;
            end
            else
            begin : g_mid_left
                assign left_value = cell_value[gi-1];
                assign left_valid = cell_valid[gi-1];
                assign found_in   = found_chain[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_value = '0;
                assign right_valid = 1'b0;
            end
            else
            begin : g_mid_right
                assign right_value = cell_value[gi+1];
                assign right_valid = cell_valid[gi+1];
            end

            ordlst_cell #(
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .ins_value   (ins_value),
                .left_value  (left_value),
                .left_valid  (left_valid),
                .right_value (right_value),
                .right_valid (right_valid),
                .found_in    (found_in),
                .found_out   (found_chain[gi]),
                .value       (cell_value[gi]),
                .valid       (cell_valid[gi]),
                .tail_term   (cell_tail[gi])
            );
        end
    endgenerate

    // At most one cell flags itself as the tail, so an OR over all cells
    // picks the tail value; an empty list gives zero.
    always_comb
    begin
        tail_any = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            tail_any = tail_any | cell_tail[i];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        priority if (ctrl.shift_in || ctrl.append)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.remove)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    // The pending stage carries the status while the row settles.
    assign load_rsp = pend_reg && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        pend_next        = pend_reg;
        pend_status_next = pend_status_reg;
        priority if (accept)
        begin
            pend_next        = 1'b1;
            pend_status_next = status_now;
        end
        else if (load_rsp)
        begin
            pend_next = 1'b0;
        end
        else
        begin
            pend_next = pend_reg;
        end
    end

    // The response stage samples the row after the update has landed.
    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        rsp_count_next  = rsp_count_reg;
        rsp_head_next   = rsp_head_reg;
        rsp_tail_next   = rsp_tail_reg;
        priority if (load_rsp)
        begin
            rsp_valid_next  = 1'b1;
            rsp_status_next = pend_status_reg;
            rsp_count_next  = ENTRY_CNT_W'(count_reg);
            rsp_head_next   = cell_valid[0] ? VALUE_W'(cell_value[0]) : '0;
            rsp_tail_next   = VALUE_W'(tail_any);
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        rsp_status_reg  <= rsp_status_next;
        rsp_count_reg   <= rsp_count_next;
        rsp_head_reg    <= rsp_head_next;
        rsp_tail_reg    <= rsp_tail_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.entry_count = rsp_count_reg;
    assign rsp.head_value  = rsp_head_reg;
    assign rsp.tail_value  = rsp_tail_reg;

    // The count register and the occupied cells must always agree.
    `OLIDC_ASSERT_ALWAYS(a_count_matches_cells, $countones(cell_valid) == int'(count_reg), "count differs from occupied cells")
    // Occupied cells stay packed against the head.
    `OLIDC_ASSERT_ALWAYS(a_cells_packed, ((cell_valid + 1'b1) & cell_valid) == '0, "occupied cells are not packed from the head")
    // A rejected insert leaves the count alone.
    `OLIDC_ASSERT_NEXT(a_full_insert_holds, accept && full && (req.opcode != OP_DELETE) && (req.opcode == OP_INS_HEAD || req.opcode == OP_INS_TAIL), count_reg == $past(count_reg), "rejected insert changed the count")
    // Every accepted request is held in the pending stage on the next cycle.
    `OLIDC_ASSERT_NEXT(a_accept_pends, accept, pend_reg && !req.ready, "accepted request was not held pending")

endmodule
